// ===== hw/rtl/tfry_pkg.sv =====
// Shared types, constants and helpers for the Threefry counter-based generator.
`default_nettype none

package tfry_pkg;

    // Key schedule parity constant.
    localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;

    // Number of mix-mix-inject groups after the initial key injection.
    localparam int unsigned GROUPS = 4;

    // Rotation amounts, two per group, index 0 first.
    localparam logic [7:0][5:0] ROT_AMT = {6'd21, 6'd24, 6'd32, 6'd16,
                                           6'd31, 6'd12, 6'd42, 6'd16};

    // Configuration register indexes.
    localparam logic [1:0] REG_KEY_WORD0 = 2'd0;
    localparam logic [1:0] REG_KEY_WORD1 = 2'd1;

    // Input beat.
    typedef struct packed {
        logic [63:0] counter;
        logic        batch_end;
    } in_beat_t;

    // Output beat.
    typedef struct packed {
        logic [63:0] random_word;
        logic        last_word;
    } out_beat_t;

    // Working lanes carried down the pipeline with the batch mark.
    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic        last;
    } lane_t;

    // Rotate left by 0..63 bits.
    function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] k);
        logic [127:0] d;
        d = {x, x} << k;
        return d[127:64];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tfry_mix.sv =====
// One add-rotate-xor mix as a registered pipeline stage.
`default_nettype none

module tfry_mix (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic [5:0]      rot,
    input  wire logic            valid_in,
    input  wire tfry_pkg::lane_t lanes_in,
    output logic                 valid_out,
    output tfry_pkg::lane_t      lanes_out
);

    logic            valid_reg;
    tfry_pkg::lane_t lanes_reg;
    tfry_pkg::lane_t lanes_next;

    // Lane 0 absorbs lane 1; lane 1 is rotated and mixed with the new lane 0.
    always_comb
    begin
        lanes_next.a    = lanes_in.a + lanes_in.b;
        lanes_next.b    = tfry_pkg::rotl(lanes_in.b, rot) ^ lanes_next.a;
        lanes_next.last = lanes_in.last;
    end

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lanes_reg <= lanes_next;
        end
    end

    assign valid_out = valid_reg;
    assign lanes_out = lanes_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tfry_inject.sv =====
// One key injection as a registered pipeline stage.
`default_nettype none

module tfry_inject (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic [63:0]     key_a,
    input  wire logic [63:0]     key_b,
    input  wire logic            valid_in,
    input  wire tfry_pkg::lane_t lanes_in,
    output logic                 valid_out,
    output tfry_pkg::lane_t      lanes_out
);

    logic            valid_reg;
    tfry_pkg::lane_t lanes_reg;
    tfry_pkg::lane_t lanes_next;

    // Each lane gets its schedule word added.
    always_comb
    begin
        lanes_next.a    = lanes_in.a + key_a;
        lanes_next.b    = lanes_in.b + key_b;
        lanes_next.last = lanes_in.last;
    end

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lanes_reg <= lanes_next;
        end
    end

    assign valid_out = valid_reg;
    assign lanes_out = lanes_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/counter_prng_threefry_top.sv =====
// Throughput: one beat per cycle while the sink does not stall.
// The 13-stage pipeline advances as a whole.
// The pipeline holds while the last stage has a beat that the sink stalls.
// Reset (rst_n, asynchronous, active low) clears all stage valid bits and both key words.
// The last pipeline stage is the output register.
`default_nettype none

module counter_prng_threefry_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [63:0]         cfg_data,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire tfry_pkg::in_beat_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output tfry_pkg::out_beat_t      out_data
);

    localparam int unsigned NSTAGE = 1 + 3 * tfry_pkg::GROUPS;

    logic [63:0] key_word0_reg;
    logic [63:0] key_word1_reg;
    logic [63:0] sched [0:2];
    logic [63:0] inj_b_reg [0:tfry_pkg::GROUPS-1];

    logic            adv;
    logic            stage_v [0:NSTAGE-1];
    tfry_pkg::lane_t stage_l [0:NSTAGE-1];
    tfry_pkg::lane_t lanes_init;

    // Key registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_word0_reg <= '0;
            key_word1_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tfry_pkg::REG_KEY_WORD0: key_word0_reg <= cfg_data;
                tfry_pkg::REG_KEY_WORD1: key_word1_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Key schedule; the third word keeps the schedule's parity.
    always_comb
    begin
        sched[0] = key_word0_reg;
        sched[1] = key_word1_reg;
        sched[2] = tfry_pkg::GOLDEN ^ key_word0_reg ^ key_word1_reg;
    end

    // Lane 1 injection words with the group number folded in ahead of time.
    always_ff @(posedge clk)
    begin
        for (int g = 0; g < tfry_pkg::GROUPS; g++)
        begin
            inj_b_reg[g] <= sched[(g + 2) % 3] + 64'(g + 1);
        end
    end

    // The whole pipeline moves unless the output beat is held by the sink.
    assign adv      = !(stage_v[NSTAGE-1] && out_stall);
    assign in_stall = !adv;

    // Lanes start as the counter and the counter xor key word 0.
    always_comb
    begin
        lanes_init.a    = in_data.counter;
        lanes_init.b    = in_data.counter ^ key_word0_reg;
        lanes_init.last = in_data.batch_end;
    end

    // Initial key injection.
    tfry_inject u_inject0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .key_a     (sched[0]),
        .key_b     (sched[1]),
        .valid_in  (in_valid),
        .lanes_in  (lanes_init),
        .valid_out (stage_v[0]),
        .lanes_out (stage_l[0])
    );

    // Four groups: two mixes, then a key injection.
    for (genvar g = 0; g < tfry_pkg::GROUPS; g++)
    begin : g_group
        localparam int unsigned S = 3 * g;

        tfry_mix u_mix0 (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .rot       (tfry_pkg::ROT_AMT[2 * g]),
            .valid_in  (stage_v[S]),
            .lanes_in  (stage_l[S]),
            .valid_out (stage_v[S + 1]),
            .lanes_out (stage_l[S + 1])
        );

        tfry_mix u_mix1 (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .rot       (tfry_pkg::ROT_AMT[2 * g + 1]),
            .valid_in  (stage_v[S + 1]),
            .lanes_in  (stage_l[S + 1]),
            .valid_out (stage_v[S + 2]),
            .lanes_out (stage_l[S + 2])
        );

        tfry_inject u_inject (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .key_a     (sched[(g + 1) % 3]),
            .key_b     (inj_b_reg[g]),
            .valid_in  (stage_v[S + 2]),
            .lanes_in  (stage_l[S + 2]),
            .valid_out (stage_v[S + 3]),
            .lanes_out (stage_l[S + 3])
        );
    end

    // Output beat is lane 0 of the last stage.
    assign out_valid            = stage_v[NSTAGE-1];
    assign out_data.random_word = stage_l[NSTAGE-1].a;
    assign out_data.last_word   = stage_l[NSTAGE-1].last;

    // An accepted input beat occupies the first stage on the next cycle.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> stage_v[0])
        else $error("accepted beat did not enter the pipeline");

    // While the sink holds the output, the first and next-to-last stage valid bits do not change.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(stage_v[0]) && $stable(stage_v[NSTAGE-2])))
        else $error("pipeline moved under an output stall");

    // A beat in the next-to-last stage reaches the output when the pipeline advances.
    a_reach: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_v[NSTAGE-2] && adv) |=> out_valid)
        else $error("beat lost before the output stage");

endmodule

`default_nettype wire
